@@ rtl/tftprr_pkg.sv @@
// shared types and constants for the tftp read receiver
package tftprr_pkg;

	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned HDR_BYTES = 4;

	localparam logic [15:0] OPC_DATA = 16'd3;
	localparam logic [15:0] OPC_ERROR = 16'd5;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	localparam logic [3:0] REG_MAX_FILE_BYTES = 4'd0;
	localparam logic [3:0] REG_MAX_RETRY_COUNT = 4'd1;

	localparam logic [31:0] MAX_FILE_BYTES_RESET = 32'd1048576;
	localparam logic [7:0] MAX_RETRY_COUNT_RESET = 8'd5;

	typedef enum logic [3:0] {
		CODE_IGNORED = 4'd0,
		CODE_ACCEPTED = 4'd1,
		CODE_OUT_OF_ORDER = 4'd2,
		CODE_TOO_LARGE = 4'd3,
		CODE_ERROR = 4'd4,
		CODE_RETRY = 4'd5,
		CODE_EXHAUSTED = 4'd6,
		CODE_DONE = 4'd7,
		CODE_INACTIVE = 4'd8
	} result_code_t;

	typedef struct packed {
		logic op;
		logic [15:0] packet_opcode;
		logic [15:0] packet_block;
		logic [15:0] packet_length;
	} item_t;

	typedef struct packed {
		logic [15:0] blocks_received;
		logic any_block_acked;
		logic [7:0] retries_used;
		logic [31:0] bytes_received;
		logic transfer_closed;
	} xfer_state_t;

	typedef struct packed {
		logic [31:0] max_file_bytes;
		logic [7:0] max_retry_count;
	} cfg_regs_t;

	typedef struct packed {
		logic send_ack;
		logic [15:0] ack_block;
		logic resend;
		logic resend_is_request;
		logic append_payload;
		logic [15:0] payload_bytes;
		logic submit_file;
		logic close_link;
		logic drop_transfer;
		result_code_t result_code;
	} result_t;

endpackage

@@ rtl/tftp_read_receiver.sv @@
// tftp read receiver top level: input register, state, result register
//
//  channel  direction  signals                      content
//  s_       in         s_tvalid s_tready s_tdata    header or timeout tick (op in s_tuser)
//  m_       out        m_tvalid m_tready m_tdata    one result per item
//  cfg_     in         cfg_valid cfg_ready          register index and write data
//
// one item per cycle when the result is not stalled; each item passes the input register, then the result register
// the input register feeds the step logic, the state updates as the result register loads
// reset clears the state and loads the register defaults; no clearing pass
// a stalled result holds the result register, and the input register keeps taking an
// item only when it is empty or the result register can load
module tftp_read_receiver (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [47:0] s_tdata, // packet_opcode, packet_block, packet_length
	input logic s_tuser, // op
	output logic m_tvalid,
	input logic m_tready,
	// send_ack, ack_block, resend, resend_is_request, append_payload, payload_bytes,
	// submit_file, close_link, drop_transfer, result_code, zero fill
	output logic [47:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [3:0] cfg_index,
	input logic [31:0] cfg_data
);
	import tftprr_pkg::*;

	item_t item_s1;
	logic valid_s1;
	xfer_state_t state_q;
	xfer_state_t state_next;
	cfg_regs_t cfg_q;
	result_t res;
	logic [47:0] m_tdata_q;
	logic m_tvalid_q;
	logic advance;

	assign advance = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_file_bytes <= MAX_FILE_BYTES_RESET;
			cfg_q.max_retry_count <= MAX_RETRY_COUNT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_FILE_BYTES) begin
				cfg_q.max_file_bytes <= cfg_data;
			end else if (cfg_index == REG_MAX_RETRY_COUNT) begin
				cfg_q.max_retry_count <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op <= s_tuser;
			item_s1.packet_opcode <= s_tdata[15:0];
			item_s1.packet_block <= s_tdata[31:16];
			item_s1.packet_length <= s_tdata[47:32];
		end
	end

	tftprr_step u_step (
		.item(item_s1),
		.cur(state_q),
		.cfg(cfg_q),
		.res(res),
		.nxt(state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata_q <= {5'd0, res.result_code, res.drop_transfer, res.close_link,
				res.submit_file, res.payload_bytes, res.append_payload,
				res.resend_is_request, res.resend, res.ack_block, res.send_ack};
		end
	end

endmodule

@@ rtl/tftprr_step.sv @@
// per-item decision logic: result and next transfer state
module tftprr_step (
	input tftprr_pkg::item_t item,
	input tftprr_pkg::xfer_state_t cur,
	input tftprr_pkg::cfg_regs_t cfg,
	output tftprr_pkg::result_t res,
	output tftprr_pkg::xfer_state_t nxt
);
	import tftprr_pkg::*;

	logic [15:0] expected_block;
	logic [15:0] payload;
	logic [32:0] total;
	logic too_large;
	logic [7:0] retry_next;

	assign expected_block = cur.blocks_received + 16'd1;
	assign payload = (item.packet_length < 16'(HDR_BYTES)) ? 16'd0
		: item.packet_length - 16'(HDR_BYTES);
	// total never exceeds the limit when kept, so no saturation is needed
	assign total = {1'b0, cur.bytes_received} + {17'd0, payload};
	assign too_large = total > {1'b0, cfg.max_file_bytes};
	assign retry_next = (cur.retries_used == 8'hff) ? 8'hff : cur.retries_used + 8'd1;

	always_comb begin
		res = '0;
		res.result_code = CODE_IGNORED;
		nxt = cur;
		if (cur.transfer_closed) begin
			res.result_code = CODE_INACTIVE;
		end else if (item.op == OP_TIMEOUT) begin
			nxt.retries_used = retry_next;
			if (retry_next < cfg.max_retry_count) begin
				res.resend = 1'b1;
				res.resend_is_request = !cur.any_block_acked;
				res.ack_block = cur.any_block_acked ? cur.blocks_received : 16'd0;
				res.result_code = CODE_RETRY;
			end else begin
				res.drop_transfer = 1'b1;
				nxt.transfer_closed = 1'b1;
				res.result_code = CODE_EXHAUSTED;
			end
		end else if (item.packet_opcode == OPC_ERROR) begin
			res.close_link = 1'b1;
			nxt.transfer_closed = 1'b1;
			res.result_code = CODE_ERROR;
		end else if (item.packet_opcode == OPC_DATA) begin
			nxt.retries_used = 8'd0;
			if (item.packet_block != expected_block) begin
				res.result_code = CODE_OUT_OF_ORDER;
			end else begin
				res.send_ack = 1'b1;
				res.ack_block = item.packet_block;
				nxt.any_block_acked = 1'b1;
				nxt.blocks_received = item.packet_block;
				if (too_large) begin
					res.close_link = 1'b1;
					res.drop_transfer = 1'b1;
					nxt.transfer_closed = 1'b1;
					res.result_code = CODE_TOO_LARGE;
				end else begin
					nxt.bytes_received = total[31:0];
					res.append_payload = 1'b1;
					res.payload_bytes = payload;
					if (payload < 16'(BLOCK_BYTES)) begin
						res.submit_file = 1'b1;
						res.close_link = 1'b1;
						nxt.transfer_closed = 1'b1;
						res.result_code = CODE_DONE;
					end else begin
						res.result_code = CODE_ACCEPTED;
					end
				end
			end
		end
	end

endmodule

@@ rtl/tftprr_checker.sv @@
// port-level checks for the tftp read receiver, bound to the top level
module tftprr_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [47:0] m_tdata
);
	import tftprr_pkg::*;

	logic [3:0] code;
	assign code = m_tdata[42:39];

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an ack goes out only for an in-order data block
	a_ack_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> code == CODE_ACCEPTED || code == CODE_TOO_LARGE
			|| code == CODE_DONE)
		else $error("ack with wrong result code");

	// payload length only with an append
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[19] |-> m_tdata[35:20] == 16'd0)
		else $error("payload length without append");

	// submitting the file also appends, closes the link and is reported as done
	a_submit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36] |-> m_tdata[37] && m_tdata[19] && code == CODE_DONE)
		else $error("submit without close or done code");

endmodule

bind tftp_read_receiver tftprr_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

@@ tb/tftp_read_receiver_tb.sv @@
// self-checking testbench for the tftp read receiver: directed table, back-to-back burst, random phases
module tftp_read_receiver_tb;
	import tftprr_pkg::*;

	typedef struct {
		item_t pkt;
		bit typed;
		result_t want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0; // packet_opcode, packet_block, packet_length
	logic s_tuser = 1'b0; // op
	logic m_tvalid;
	logic m_tready = 1'b0;
	// send_ack, ack_block, resend, resend_is_request, append_payload, payload_bytes,
	// submit_file, close_link, drop_transfer, result_code, zero fill
	logic [47:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// shadow of the transfer state and the registers
	logic [15:0] ex_blocks;
	logic ex_acked;
	logic [7:0] ex_retries;
	logic [31:0] ex_bytes;
	logic ex_closed;
	logic [31:0] cfg_max_bytes;
	logic [7:0] cfg_max_retry;

	result_t pending_replies [$];
	step_row_t steps [$];
	int mismatches = 0;
	bit no_idle = 1'b0;

	tftp_read_receiver i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 21);
	end

	function automatic item_t hdr(input logic op, input logic [15:0] opc,
			input logic [15:0] blk, input logic [15:0] len);
		item_t pkt;
		pkt = {op, opc, blk, len};
		return pkt;
	endfunction

	// one step of the receiver; updates the shadow state
	function automatic result_t receiver_step(input item_t pkt);
		result_t r;
		logic [8:0] tries;
		logic [15:0] payload;
		logic [32:0] total;
		r = '0;
		r.result_code = CODE_IGNORED;
		if (ex_closed) begin
			r.result_code = CODE_INACTIVE;
		end else if (pkt.op == OP_TIMEOUT) begin
			tries = {1'b0, ex_retries} + 9'd1;
			if (tries > 9'd255)
				tries = 9'd255;
			ex_retries = tries[7:0];
			if (tries[7:0] < cfg_max_retry) begin
				r.resend = 1'b1;
				if (ex_acked)
					r.ack_block = ex_blocks;
				else
					r.resend_is_request = 1'b1;
				r.result_code = CODE_RETRY;
			end else begin
				r.drop_transfer = 1'b1;
				ex_closed = 1'b1;
				r.result_code = CODE_EXHAUSTED;
			end
		end else if (pkt.packet_opcode == OPC_ERROR) begin
			r.close_link = 1'b1;
			ex_closed = 1'b1;
			r.result_code = CODE_ERROR;
		end else if (pkt.packet_opcode == OPC_DATA) begin
			ex_retries = '0;
			if (pkt.packet_block != 16'(ex_blocks + 16'd1)) begin
				r.result_code = CODE_OUT_OF_ORDER;
			end else begin
				r.send_ack = 1'b1;
				r.ack_block = pkt.packet_block;
				ex_acked = 1'b1;
				ex_blocks = pkt.packet_block;
				payload = (pkt.packet_length < 16'(HDR_BYTES)) ? 16'd0
						: pkt.packet_length - 16'(HDR_BYTES);
				total = {1'b0, ex_bytes} + {17'd0, payload};
				if (total > {1'b0, cfg_max_bytes}) begin
					r.close_link = 1'b1;
					r.drop_transfer = 1'b1;
					ex_closed = 1'b1;
					r.result_code = CODE_TOO_LARGE;
				end else begin
					ex_bytes = total[32] ? 32'hFFFF_FFFF : total[31:0];
					r.append_payload = 1'b1;
					r.payload_bytes = payload;
					if (payload < 16'(BLOCK_BYTES)) begin
						r.submit_file = 1'b1;
						r.close_link = 1'b1;
						ex_closed = 1'b1;
						r.result_code = CODE_DONE;
					end else begin
						r.result_code = CODE_ACCEPTED;
					end
				end
			end
		end
		return r;
	endfunction

	// random header or tick that keeps the transfer open
	function automatic item_t pick_packet();
		item_t pkt;
		int unsigned pick;
		pkt.op = OP_PACKET;
		pkt.packet_opcode = 16'($urandom_range(0, 65535));
		pkt.packet_block = 16'($urandom_range(0, 65535));
		pkt.packet_length = 16'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 15 && ex_retries + 1 < cfg_max_retry) begin
			pkt.op = OP_TIMEOUT;
		end else if (pick < 25) begin
			while (pkt.packet_opcode == OPC_DATA || pkt.packet_opcode == OPC_ERROR)
				pkt.packet_opcode = 16'($urandom_range(0, 65535));
		end else if (pick < 37) begin
			pkt.packet_opcode = OPC_DATA;
			pkt.packet_block = ex_blocks + 16'd1 + 16'($urandom_range(1, 65535));
		end else begin
			pkt.packet_opcode = OPC_DATA;
			pkt.packet_block = ex_blocks + 16'd1;
			if ($urandom_range(0, 99) < 8)
				pkt.packet_length = 16'($urandom_range(1101, 65535));
			else
				pkt.packet_length = 16'($urandom_range(516, 1100));
			// a block that would overflow the limit goes out as a duplicate instead
			if ({1'b0, ex_bytes} + 33'(pkt.packet_length - 16'(HDR_BYTES))
					> {1'b0, cfg_max_bytes})
				pkt.packet_block = ex_blocks;
		end
		return pkt;
	endfunction

	task automatic send_item(input item_t pkt, input bit typed, input result_t want);
		result_t predicted;
		while (!no_idle && $urandom_range(0, 99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pkt.packet_length, pkt.packet_block, pkt.packet_opcode};
		s_tuser <= pkt.op;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = receiver_step(pkt);
		pending_replies.push_back(typed ? want : predicted);
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
		drain_replies();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MAX_FILE_BYTES)
			cfg_max_bytes = val;
		else if (idx == REG_MAX_RETRY_COUNT)
			cfg_max_retry = val[7:0];
	endtask

	task automatic run_phase(input logic [31:0] max_bytes, input logic [7:0] max_retry,
			input int count);
		write_reg(REG_MAX_FILE_BYTES, max_bytes);
		write_reg(REG_MAX_RETRY_COUNT, {24'd0, max_retry});
		for (int i = 0; i < count; i++)
			send_item(pick_packet(), 1'b0, '0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : reply_monitor
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, expected none, actual %h",
						$time, m_tdata);
			end else begin
				want = pending_replies.pop_front();
				check_field("send_ack", 32'(want.send_ack), 32'(m_tdata[0]));
				check_field("ack_block", 32'(want.ack_block), 32'(m_tdata[16:1]));
				check_field("resend", 32'(want.resend), 32'(m_tdata[17]));
				check_field("resend_is_request", 32'(want.resend_is_request),
						32'(m_tdata[18]));
				check_field("append_payload", 32'(want.append_payload), 32'(m_tdata[19]));
				check_field("payload_bytes", 32'(want.payload_bytes), 32'(m_tdata[35:20]));
				check_field("submit_file", 32'(want.submit_file), 32'(m_tdata[36]));
				check_field("close_link", 32'(want.close_link), 32'(m_tdata[37]));
				check_field("drop_transfer", 32'(want.drop_transfer), 32'(m_tdata[38]));
				check_field("result_code", 32'(want.result_code), 32'(m_tdata[42:39]));
			end
		end
	end

	initial begin
		#20000000;
		$display("tftp_read_receiver_tb: done, errors");
		$finish;
	end

	initial begin
		item_t pkt;
		int ending;
		ex_blocks = '0;
		ex_acked = 1'b0;
		ex_retries = '0;
		ex_bytes = '0;
		ex_closed = 1'b0;
		cfg_max_bytes = MAX_FILE_BYTES_RESET;
		cfg_max_retry = MAX_RETRY_COUNT_RESET;

		// fields: send_ack ack_block resend req append payload submit close drop code
		steps.push_back('{hdr(OP_PACKET, 16'h0000, 16'h0000, 16'h0000), 1'b1,
				'{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CODE_IGNORED}});
		steps.push_back('{hdr(OP_PACKET, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
				'{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CODE_IGNORED}});
		// no block acked yet: the read request goes out again
		steps.push_back('{hdr(OP_TIMEOUT, 16'h0000, 16'h0000, 16'h0000), 1'b1,
				'{1'b0, 16'd0, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CODE_RETRY}});
		steps.push_back('{hdr(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
				'{1'b0, 16'd0, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CODE_RETRY}});
		steps.push_back('{hdr(OP_TIMEOUT, OPC_DATA, 16'h0001, 16'h0204), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0000, 16'hFFFF), 1'b1,
				'{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CODE_OUT_OF_ORDER}});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'hFFFF, 16'h0002), 1'b1,
				'{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CODE_OUT_OF_ORDER}});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0001, 16'd516), 1'b1,
				'{1'b1, 16'd1, 1'b0, 1'b0, 1'b1, 16'd512, 1'b0, 1'b0, 1'b0, CODE_ACCEPTED}});
		// after an ack the last ack is resent
		steps.push_back('{hdr(OP_TIMEOUT, 16'h0000, 16'h0000, 16'h0000), 1'b1,
				'{1'b0, 16'd1, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, CODE_RETRY}});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0002, 16'd517), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0003, 16'hFFFF), 1'b1,
				'{1'b1, 16'd3, 1'b0, 1'b0, 1'b1, 16'd65531, 1'b0, 1'b0, 1'b0, CODE_ACCEPTED}});
		steps.push_back('{hdr(OP_PACKET, 16'h0004, 16'h0003, 16'h0004), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, 16'h0001, 16'h0004, 16'h0204), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, 16'h0002, 16'h8000, 16'h8000), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0003, 16'h0204), 1'b0, '0});
		// op wins over a data or error opcode
		steps.push_back('{hdr(OP_TIMEOUT, OPC_DATA, 16'h0004, 16'h0204), 1'b0, '0});
		steps.push_back('{hdr(OP_TIMEOUT, OPC_ERROR, 16'h0004, 16'h0204), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0005, 16'h0204), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0006, 16'h0003), 1'b0, '0});
		steps.push_back('{hdr(OP_PACKET, OPC_DATA, 16'h0004, 16'd516), 1'b0, '0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i])
			send_item(steps[i].pkt, steps[i].typed, steps[i].want);

		// long run of timeouts up to one below the retry limit
		write_reg(REG_MAX_FILE_BYTES, 32'hFFFF_FFFF);
		write_reg(REG_MAX_RETRY_COUNT, 32'd64);
		while (ex_retries + 1 < cfg_max_retry)
			send_item(hdr(OP_TIMEOUT, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))),
					1'b0, '0);

		// back-to-back in-order blocks with no idling
		no_idle = 1'b1;
		repeat (60)
			send_item(hdr(OP_PACKET, OPC_DATA, ex_blocks + 16'd1, 16'd516), 1'b0, '0);
		send_item(hdr(OP_PACKET, OPC_DATA, ex_blocks, 16'd600), 1'b0, '0);
		send_item(hdr(OP_PACKET, OPC_DATA, ex_blocks + 16'd1,
				16'($urandom_range(516, 65535))), 1'b0, '0);
		no_idle = 1'b0;

		run_phase(32'hFFFF_FFFF, 8'd255, 170);
		run_phase(32'd0, 8'd0, 30);
		run_phase(ex_bytes + 32'($urandom_range(1 << 20, 1 << 24)),
				8'($urandom_range(2, 254)), 210);
		run_phase(32'hFFFF_FFFF, 8'd1, 80);
		run_phase(32'hFFFF_FFFF, 8'd2, 130);
		run_phase(32'hFFFF_FFFF, 8'd5, 170);

		// the transfer can end only once per run, so the way it ends is drawn at random
		ending = $urandom_range(0, 3);
		case (ending)
			0: begin
				send_item(hdr(OP_PACKET, OPC_ERROR, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535))), 1'b0, '0);
			end
			1: begin
				pkt = hdr(OP_PACKET, OPC_DATA, ex_blocks + 16'd1,
						16'($urandom_range(4, 515)));
				if ($urandom_range(0, 1) == 0)
					pkt.packet_length = 16'($urandom_range(0, 3));
				send_item(pkt, 1'b0, '0);
			end
			2: begin
				write_reg(REG_MAX_FILE_BYTES, 32'd0);
				send_item(hdr(OP_PACKET, OPC_DATA, ex_blocks + 16'd1,
						16'($urandom_range(0, 65535))), 1'b0, '0);
			end
			default: begin
				write_reg(REG_MAX_RETRY_COUNT, 32'($urandom_range(0, 1)));
				send_item(hdr(OP_TIMEOUT, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))),
						1'b0, '0);
			end
		endcase

		// everything after the end answers inactive
		for (int i = 0; i < 12; i++)
			send_item(hdr(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))),
					1'b0, '0);

		drain_replies();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tftp_read_receiver_tb: done, clean");
		else
			$display("tftp_read_receiver_tb: done, errors");
		$finish;
	end

endmodule
